// ----- hdl/dfp_pkg.sv -----
package dfp_pkg;

    // Event codes carried on event_res
    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_FRAME_OK  = 3'd1,
        EV_CHECK_ERR = 3'd2,
        EV_DATA      = 3'd3,
        EV_PIXEL     = 3'd4,
        EV_SYNC_LOST = 3'd5
    } event_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_BITMAP = 3'd0,
        CFG_SPI    = 3'd1,
        CFG_FILE   = 3'd2,
        CFG_NAME   = 3'd3,
        CFG_BOOT   = 3'd4,
        CFG_APP    = 3'd5
    } cfg_index_t;

    localparam int          CFG_COUNT   = 6;
    localparam int          CFG_IDX_W   = 3;
    localparam int          CFG_DATA_W  = 8;

    // Command codes after reset
    localparam logic [7:0]  RST_BITMAP  = 8'd1;
    localparam logic [7:0]  RST_SPI     = 8'd8;
    localparam logic [7:0]  RST_FILE    = 8'd35;
    localparam logic [7:0]  RST_NAME    = 8'd36;
    localparam logic [7:0]  RST_BOOT    = 8'd38;
    localparam logic [7:0]  RST_APP     = 8'd39;

    // Frame layout
    localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND = 8'h55;
    localparam logic [23:0] FRAME_CMD   = 24'd2;
    localparam logic [23:0] FRAME_ADDR_LAST = 24'd5;
    localparam logic [23:0] FRAME_CHECK = 24'd9;

    // Bitmap header layout
    localparam logic [23:0] BMP_HDR_LEN   = 24'h36;
    localparam logic [23:0] BMP_WIDTH_LO  = 24'h12;
    localparam logic [23:0] BMP_WIDTH_HI  = 24'h15;
    localparam logic [23:0] BMP_HEIGHT_LO = 24'h16;
    localparam logic [23:0] BMP_HEIGHT_HI = 24'h19;

    localparam int          DIM_BITS_DEFAULT = 16;

endpackage

// ----- hdl/download_frame_parser_unit.sv -----
// Serial download frame parser: one received byte per request.
// Latency: the result of a byte is registered at the edge that accepts it and
// is offered on the output channel from the next cycle.
// Throughput: one byte per cycle, set by the single result register; a new
// byte is taken whenever the result register is empty or being drained.
// Reset (rst_n low, asynchronous): hunt for the header, command codes to defaults.
module download_frame_parser_unit #(
    parameter int DIM_BITS = dfp_pkg::DIM_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           cfg_we,
    input  logic [dfp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dfp_pkg::CFG_DATA_W-1:0] cfg_data,

    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     rx_byte,

    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [2:0]                     event_res,
    output logic [7:0]                     frame_command,
    output logic [23:0]                    frame_address,
    output logic [23:0]                    frame_length,
    output logic [7:0]                     byte_value,
    output logic [23:0]                    byte_offset,
    output logic [15:0]                    pixel_x,
    output logic [15:0]                    pixel_y,
    output logic [15:0]                    pixel_color,
    output logic                           send_ack,
    output logic                           transfer_end,
    output logic                           write_terminator
);

    localparam int EXT_W = (DIM_BITS > 16) ? DIM_BITS : 16;

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_FRAME = 2'd1,
        PH_DATA  = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        K_BITMAP = 3'd0,
        K_SPI    = 3'd1,
        K_FILE   = 3'd2,
        K_NAME   = 3'd3,
        K_BOOT   = 3'd4,
        K_APP    = 3'd5,
        K_OTHER  = 3'd6
    } kind_t;

    // Registers
    logic [7:0]          cfg_reg [dfp_pkg::CFG_COUNT];
    phase_t              phase_reg,       phase_next;
    logic [23:0]         count_reg,       count_next;
    logic [7:0]          check_reg,       check_next;
    logic [7:0]          cmd_reg,         cmd_next;
    logic [23:0]         addr_reg,        addr_next;
    logic [23:0]         len_reg,         len_next;
    logic                hdr_done_reg,    hdr_done_next;
    logic [DIM_BITS-1:0] width_reg,       width_next;
    logic [DIM_BITS-1:0] height_reg,      height_next;
    logic [1:0]          colour_cnt_reg,  colour_cnt_next;
    logic [4:0]          red_reg,         red_next;
    logic [5:0]          green_reg,       green_next;
    logic [DIM_BITS-1:0] column_reg,      column_next;
    logic [DIM_BITS-1:0] rows_reg,        rows_next;

    logic                out_valid_reg,   out_valid_next;
    dfp_pkg::event_t     ev_reg,          ev_next;
    logic [7:0]          o_cmd_reg,       o_cmd_next;
    logic [23:0]         o_addr_reg,      o_addr_next;
    logic [23:0]         o_len_reg,       o_len_next;
    logic [7:0]          o_byte_reg,      o_byte_next;
    logic [23:0]         o_offset_reg,    o_offset_next;
    logic [15:0]         o_x_reg,         o_x_next;
    logic [15:0]         o_y_reg,         o_y_next;
    logic [15:0]         o_colour_reg,    o_colour_next;
    logic                o_ack_reg,       o_ack_next;
    logic                o_end_reg,       o_end_next;
    logic                o_term_reg,      o_term_next;

    logic                in_fire;
    kind_t               kind;
    logic                show_frame;
    logic [23:0]         count_inc;
    logic [DIM_BITS-1:0] column_inc;
    logic [DIM_BITS-1:0] row_index;
    logic [EXT_W-1:0]    x_ext;
    logic [EXT_W-1:0]    y_ext;
    logic [1:0]          lane;

    // Byte lane within the width or height field
    function automatic logic [1:0] BMP_LANE_BASE(input logic [23:0] idx);
        logic [1:0] base;
        base = (idx >= dfp_pkg::BMP_HEIGHT_LO) ? dfp_pkg::BMP_HEIGHT_LO[1:0]
                                                : dfp_pkg::BMP_WIDTH_LO[1:0];
        return base;
    endfunction

    // Take a request whenever the result register can move on
    assign in_stall = out_valid_reg & out_stall;
    assign in_fire  = in_valid & ~in_stall;

    // Classify the held command, first match wins
    always_comb
    begin
        if (cmd_reg == cfg_reg[dfp_pkg::CFG_BITMAP])
            kind = K_BITMAP;
        else if (cmd_reg == cfg_reg[dfp_pkg::CFG_SPI])
            kind = K_SPI;
        else if (cmd_reg == cfg_reg[dfp_pkg::CFG_FILE])
            kind = K_FILE;
        else if (cmd_reg == cfg_reg[dfp_pkg::CFG_NAME])
            kind = K_NAME;
        else if (cmd_reg == cfg_reg[dfp_pkg::CFG_BOOT])
            kind = K_BOOT;
        else if (cmd_reg == cfg_reg[dfp_pkg::CFG_APP])
            kind = K_APP;
        else
            kind = K_OTHER;
    end

    assign count_inc  = count_reg + 24'd1;
    assign column_inc = column_reg + DIM_BITS'(1);
    assign row_index  = rows_reg - DIM_BITS'(1);
    assign x_ext      = EXT_W'(column_reg);
    assign y_ext      = EXT_W'(row_index);
    assign lane       = count_reg[1:0] - BMP_LANE_BASE(count_reg);

    // Work out the next state and the result of one byte
    always_comb
    begin
        phase_next      = phase_reg;
        count_next      = count_reg;
        check_next      = check_reg;
        cmd_next        = cmd_reg;
        addr_next       = addr_reg;
        len_next        = len_reg;
        hdr_done_next   = hdr_done_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        colour_cnt_next = colour_cnt_reg;
        red_next        = red_reg;
        green_next      = green_reg;
        column_next     = column_reg;
        rows_next       = rows_reg;

        show_frame      = 1'b0;
        ev_next         = dfp_pkg::EV_NONE;
        o_byte_next     = '0;
        o_offset_next   = '0;
        o_x_next        = '0;
        o_y_next        = '0;
        o_colour_next   = '0;
        o_ack_next      = 1'b0;
        o_end_next      = 1'b0;
        o_term_next     = 1'b0;

        case (phase_reg)
            PH_FRAME:
            begin
                if (count_reg < dfp_pkg::FRAME_CHECK)
                begin
                    // Collect a frame byte
                    check_next = check_reg ^ rx_byte;
                    if (count_reg == dfp_pkg::FRAME_CMD)
                        cmd_next = rx_byte;
                    else if (count_reg <= dfp_pkg::FRAME_ADDR_LAST)
                        addr_next = {addr_reg[15:0], rx_byte};
                    else
                        len_next = {len_reg[15:0], rx_byte};
                    count_next = count_inc;
                end
                else if (rx_byte != check_reg)
                begin
                    // Drop the frame and hunt again
                    ev_next         = dfp_pkg::EV_CHECK_ERR;
                    phase_next      = PH_HUNT;
                    count_next      = '0;
                    hdr_done_next   = 1'b0;
                    colour_cnt_next = '0;
                end
                else
                begin
                    ev_next         = dfp_pkg::EV_FRAME_OK;
                    show_frame      = 1'b1;
                    count_next      = '0;
                    hdr_done_next   = 1'b0;
                    colour_cnt_next = '0;
                    o_ack_next      = (kind == K_FILE) || (kind == K_NAME) ||
                                      (kind == K_BOOT) || (kind == K_APP);
                    if (kind == K_OTHER)
                    begin
                        o_end_next = 1'b1;
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
            end

            PH_DATA:
            begin
                show_frame = 1'b1;
                count_next = count_inc;
                if (kind == K_BOOT || kind == K_SPI || kind == K_FILE ||
                    kind == K_NAME || kind == K_APP)
                begin
                    // Pass a store byte on
                    ev_next       = dfp_pkg::EV_DATA;
                    o_byte_next   = rx_byte;
                    o_offset_next = count_reg;
                end
                else if (kind == K_BITMAP && !hdr_done_reg)
                begin
                    // Pick width and height out of the bitmap header
                    if (count_reg == '0)
                    begin
                        width_next  = '0;
                        height_next = '0;
                    end
                    else if (count_reg inside {[dfp_pkg::BMP_WIDTH_LO:dfp_pkg::BMP_WIDTH_HI]})
                    begin
                        for (int j = 0; j < DIM_BITS; j++)
                        begin
                            if ((j >> 3) == int'(lane))
                                width_next[j] = width_reg[j] | rx_byte[j & 7];
                        end
                    end
                    else if (count_reg inside
                             {[dfp_pkg::BMP_HEIGHT_LO:dfp_pkg::BMP_HEIGHT_HI]})
                    begin
                        for (int j = 0; j < DIM_BITS; j++)
                        begin
                            if ((j >> 3) == int'(lane))
                                height_next[j] = height_reg[j] | rx_byte[j & 7];
                        end
                    end
                    if (count_inc >= dfp_pkg::BMP_HDR_LEN)
                    begin
                        rows_next       = height_next;
                        column_next     = '0;
                        colour_cnt_next = '0;
                        hdr_done_next   = 1'b1;
                    end
                end
                else if (kind == K_BITMAP)
                begin
                    // Gather red, green, then blue and emit the pixel
                    case (colour_cnt_reg)
                        2'd0:
                        begin
                            red_next        = rx_byte[7:3];
                            colour_cnt_next = 2'd1;
                        end
                        2'd1:
                        begin
                            green_next      = rx_byte[7:2];
                            colour_cnt_next = 2'd2;
                        end
                        default:
                        begin
                            colour_cnt_next = 2'd0;
                            ev_next         = dfp_pkg::EV_PIXEL;
                            o_x_next        = x_ext[15:0];
                            o_y_next        = y_ext[15:0];
                            o_colour_next   = {rx_byte[7:3], green_reg, red_reg};
                            if (column_inc >= width_reg)
                            begin
                                rows_next   = row_index;
                                column_next = '0;
                            end
                            else
                            begin
                                column_next = column_inc;
                            end
                        end
                    endcase
                end

                // End the transfer once the length is reached
                if (count_inc >= len_reg)
                begin
                    o_end_next      = 1'b1;
                    o_term_next     = (kind == K_NAME);
                    phase_next      = PH_HUNT;
                    count_next      = '0;
                    hdr_done_next   = 1'b0;
                    colour_cnt_next = '0;
                end
            end

            default:
            begin
                // Hunt for the two-byte header
                if (count_reg == '0)
                begin
                    if (rx_byte == dfp_pkg::SYNC_FIRST)
                        count_next = 24'd1;
                end
                else if (rx_byte == dfp_pkg::SYNC_SECOND)
                begin
                    phase_next = PH_FRAME;
                    count_next = dfp_pkg::FRAME_CMD;
                    check_next = dfp_pkg::SYNC_FIRST ^ dfp_pkg::SYNC_SECOND;
                    cmd_next   = '0;
                    addr_next  = '0;
                    len_next   = '0;
                end
                else
                begin
                    ev_next         = dfp_pkg::EV_SYNC_LOST;
                    phase_next      = PH_HUNT;
                    count_next      = '0;
                    hdr_done_next   = 1'b0;
                    colour_cnt_next = '0;
                end
            end
        endcase

        o_cmd_next  = show_frame ? cmd_next  : '0;
        o_addr_next = show_frame ? addr_next : '0;
        o_len_next  = show_frame ? len_next  : '0;
    end

    assign out_valid_next = in_fire | (out_valid_reg & out_stall);

    // Hold state, configuration and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[dfp_pkg::CFG_BITMAP] <= dfp_pkg::RST_BITMAP;
            cfg_reg[dfp_pkg::CFG_SPI]    <= dfp_pkg::RST_SPI;
            cfg_reg[dfp_pkg::CFG_FILE]   <= dfp_pkg::RST_FILE;
            cfg_reg[dfp_pkg::CFG_NAME]   <= dfp_pkg::RST_NAME;
            cfg_reg[dfp_pkg::CFG_BOOT]   <= dfp_pkg::RST_BOOT;
            cfg_reg[dfp_pkg::CFG_APP]    <= dfp_pkg::RST_APP;
            phase_reg      <= PH_HUNT;
            count_reg      <= '0;
            check_reg      <= '0;
            cmd_reg        <= '0;
            addr_reg       <= '0;
            len_reg        <= '0;
            hdr_done_reg   <= 1'b0;
            width_reg      <= '0;
            height_reg     <= '0;
            colour_cnt_reg <= '0;
            red_reg        <= '0;
            green_reg      <= '0;
            column_reg     <= '0;
            rows_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index < dfp_pkg::CFG_IDX_W'(dfp_pkg::CFG_COUNT))
                cfg_reg[cfg_index] <= cfg_data;
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                phase_reg      <= phase_next;
                count_reg      <= count_next;
                check_reg      <= check_next;
                cmd_reg        <= cmd_next;
                addr_reg       <= addr_next;
                len_reg        <= len_next;
                hdr_done_reg   <= hdr_done_next;
                width_reg      <= width_next;
                height_reg     <= height_next;
                colour_cnt_reg <= colour_cnt_next;
                red_reg        <= red_next;
                green_reg      <= green_next;
                column_reg     <= column_next;
                rows_reg       <= rows_next;
            end
        end
    end

    // Result payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ev_reg       <= ev_next;
            o_cmd_reg    <= o_cmd_next;
            o_addr_reg   <= o_addr_next;
            o_len_reg    <= o_len_next;
            o_byte_reg   <= o_byte_next;
            o_offset_reg <= o_offset_next;
            o_x_reg      <= o_x_next;
            o_y_reg      <= o_y_next;
            o_colour_reg <= o_colour_next;
            o_ack_reg    <= o_ack_next;
            o_end_reg    <= o_end_next;
            o_term_reg   <= o_term_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign event_res        = ev_reg;
    assign frame_command    = o_cmd_reg;
    assign frame_address    = o_addr_reg;
    assign frame_length     = o_len_reg;
    assign byte_value       = o_byte_reg;
    assign byte_offset      = o_offset_reg;
    assign pixel_x          = o_x_reg;
    assign pixel_y          = o_y_reg;
    assign pixel_color      = o_colour_reg;
    assign send_ack         = o_ack_reg;
    assign transfer_end     = o_end_reg;
    assign write_terminator = o_term_reg;

`ifndef SYNTH
    // Hunting never keeps bitmap progress
    a_hunt_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HUNT) |-> (!hdr_done_reg && colour_cnt_reg == 2'd0 &&
                                    count_reg <= 24'd1))
        else $error("stale transfer state while hunting");

    // Frame collection keeps its byte index within the frame
    a_frame_index: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_FRAME) |-> (count_reg >= dfp_pkg::FRAME_CMD &&
                                     count_reg <= dfp_pkg::FRAME_CHECK))
        else $error("frame byte index out of range");

    // Acknowledge only comes with an accepted frame
    a_ack_event: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && o_ack_reg) |-> (ev_reg == dfp_pkg::EV_FRAME_OK))
        else $error("acknowledge without accepted frame");

    // Terminator only on the last byte of a transfer
    a_term_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && o_term_reg) |-> (o_end_reg && ev_reg == dfp_pkg::EV_DATA))
        else $error("terminator without transfer end");

    // A finished transfer returns to the hunt
    a_end_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && o_end_next) |=> (phase_reg == PH_HUNT))
        else $error("transfer end did not return to hunt");
`endif

endmodule
